### rtl/core/fls_pkg.sv
// ----------------------------------------------------------------------------
// fls_pkg
// Shared codes, constants and inter-module types of the FP load/store unit.
// ----------------------------------------------------------------------------
package fls_pkg;

	localparam int unsigned REG_COUNT_DEF = 32;

	// low three opcode bits
	localparam logic [2:0] CMD_LDF   = 3'd0;
	localparam logic [2:0] CMD_LDFSR = 3'd1;
	localparam logic [2:0] CMD_LDDF  = 3'd3;
	localparam logic [2:0] CMD_STF   = 3'd4;
	localparam logic [2:0] CMD_STFSR = 3'd5;
	localparam logic [2:0] CMD_STDF  = 3'd7;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_ALIGN = 2'd1;
	localparam logic [1:0] STAT_UNIMP = 2'd2;

	localparam logic [31:0] FSR_RESERVED_MASK = 32'h0030_1000;
	localparam logic [31:0] FSR_VERSION_BITS  = 32'h000E_0000;
	localparam logic [31:0] DOUBLE_ALIGN_MASK = 32'h0000_0007;
	localparam int unsigned IMM_EXT_BITS      = 19;
	localparam logic [31:0] WORD_STEP         = 32'd4;

	// decoded view of the request held in stage 1
	typedef struct packed {
		logic [31:0] ea;
		logic [31:0] trap_addr;
		logic [1:0]  status;
		logic        mem_write;
		logic        two_beat;
		logic        sel_fsr;
		logic        wr_single;
		logic        wr_pair;
		logic        wr_fsr;
	} dec_t;

	// register file write port
	typedef struct packed {
		logic        even_en;
		logic        odd_en;
		logic        fsr_en;
		logic [31:0] even_data;
		logic [31:0] odd_data;
		logic [31:0] fsr_data;
	} rf_wr_t;

endpackage

### rtl/core/fls_agen.sv
// ----------------------------------------------------------------------------
// fls_agen
// Effective address generation and opcode decode for one request.
// ----------------------------------------------------------------------------
module fls_agen (
	input  logic               [2:0]  command,
	input  logic                      immediate_mode,
	input  logic               [31:0] base_value,
	input  logic               [31:0] index_value,
	input  logic signed        [12:0] offset_immediate,
	input  logic               [31:0] instruction_address,
	output fls_pkg::dec_t             dec
);
	import fls_pkg::*;

	logic [31:0] simm;
	logic [31:0] ea;
	logic        aligned;

	assign simm    = {{IMM_EXT_BITS{offset_immediate[12]}}, offset_immediate};
	assign ea      = base_value + (immediate_mode ? simm : index_value);
	assign aligned = (ea & DOUBLE_ALIGN_MASK) == 32'd0;

	always_comb begin
		dec           = '0;
		dec.ea        = ea;
		dec.trap_addr = ea;
		dec.status    = STAT_DONE;
		case (command)
			CMD_LDF: begin
				dec.wr_single = 1'b1;
			end
			CMD_LDFSR: begin
				dec.wr_fsr = 1'b1;
			end
			CMD_LDDF: begin
				if (aligned) begin
					dec.wr_pair = 1'b1;
				end else begin
					dec.status = STAT_ALIGN;
				end
			end
			CMD_STF: begin
				dec.mem_write = 1'b1;
			end
			CMD_STFSR: begin
				dec.mem_write = 1'b1;
				dec.sel_fsr   = 1'b1;
			end
			CMD_STDF: begin
				if (aligned) begin
					dec.mem_write = 1'b1;
					dec.two_beat  = 1'b1;
				end else begin
					dec.status = STAT_ALIGN;
				end
			end
			default: begin
				dec.status    = STAT_UNIMP;
				dec.trap_addr = instruction_address;
			end
		endcase
	end

endmodule

### rtl/core/fls_regfile.sv
// ----------------------------------------------------------------------------
// fls_regfile
// FP register file split into even and odd banks, plus the FP status register.
// ----------------------------------------------------------------------------
module fls_regfile #(
	parameter int unsigned REGISTER_COUNT = fls_pkg::REG_COUNT_DEF,
	localparam int unsigned BANK_DEPTH    = REGISTER_COUNT / 2,
	localparam int unsigned BANK_AW       = $clog2(BANK_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [BANK_AW-1:0]     idx,
	input  fls_pkg::rf_wr_t        wr,
	output logic [31:0]            even_data,
	output logic [31:0]            odd_data,
	output logic [31:0]            fsr_data
);
	import fls_pkg::*;

	logic [31:0] even_q [BANK_DEPTH];
	logic [31:0] odd_q  [BANK_DEPTH];
	logic [31:0] fsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANK_DEPTH; i++) begin
				even_q[i] <= '0;
				odd_q[i]  <= '0;
			end
			fsr_q <= '0;
		end else begin
			if (wr.even_en) begin
				even_q[idx] <= wr.even_data;
			end
			if (wr.odd_en) begin
				odd_q[idx] <= wr.odd_data;
			end
			if (wr.fsr_en) begin
				fsr_q <= wr.fsr_data;
			end
		end
	end

	assign even_data = even_q[idx];
	assign odd_data  = odd_q[idx];
	assign fsr_data  = fsr_q;

endmodule

### rtl/core/fpu_load_store_unit.sv
// ----------------------------------------------------------------------------
// fpu_load_store_unit
// Executes FP load/store requests: address, decode, register file update and
// store word generation between a request register and a result register.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------
//  request   | cmd_valid/cmd_stall  | command .. instruction_address
//  result    | res_valid/res_stall  | status, memory_write .. last
//
//  A request is held in stage 1 and its result is then registered for output.
//  One result per cycle while res_stall is low; an aligned double store gives
//  two results, one per word.
//  Reset clears all FP registers and the status register at once.
//  A stalled result holds; stage 1 takes a request while it waits only if empty.
// ----------------------------------------------------------------------------
module fpu_load_store_unit #(
	parameter int unsigned REGISTER_COUNT = fls_pkg::REG_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic        [2:0]  command,
	input  logic               immediate_mode,
	input  logic        [31:0] base_value,
	input  logic        [31:0] index_value,
	input  logic signed [12:0] offset_immediate,
	input  logic        [4:0]  fp_register_number,
	input  logic        [31:0] load_word_first,
	input  logic        [31:0] load_word_second,
	input  logic        [31:0] instruction_address,
	output logic               res_valid,
	input  logic               res_stall,
	output logic        [1:0]  status,
	output logic               memory_write,
	output logic        [31:0] memory_address,
	output logic        [31:0] memory_data,
	output logic        [31:0] trap_address,
	output logic               last
);
	import fls_pkg::*;

	localparam int unsigned BANK_AW = $clog2(REGISTER_COUNT / 2);

	// stage 1 request register
	logic               valid_s1;
	logic               beat_s1;
	logic        [2:0]  command_s1;
	logic               imode_s1;
	logic        [31:0] base_s1;
	logic        [31:0] index_s1;
	logic signed [12:0] imm_s1;
	logic        [4:0]  rd_s1;
	logic        [31:0] w0_s1;
	logic        [31:0] w1_s1;
	logic        [31:0] pc_s1;

	// result register
	logic        res_valid_q;
	logic [1:0]  status_q;
	logic        mem_write_q;
	logic [31:0] mem_addr_q;
	logic [31:0] mem_data_q;
	logic [31:0] trap_addr_q;
	logic        last_q;

	dec_t        dec;
	rf_wr_t      rf_wr;
	logic [31:0] even_data;
	logic [31:0] odd_data;
	logic [31:0] fsr_data;
	logic [31:0] store_word;
	logic        pick_odd;
	logic        out_free;
	logic        s1_go;
	logic        s1_done;
	logic        cmd_take;

	fls_agen u_agen (
		.command             (command_s1),
		.immediate_mode      (imode_s1),
		.base_value          (base_s1),
		.index_value         (index_s1),
		.offset_immediate    (imm_s1),
		.instruction_address (pc_s1),
		.dec                 (dec)
	);

	fls_regfile #(
		.REGISTER_COUNT (REGISTER_COUNT)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.idx       (rd_s1[BANK_AW:1]),
		.wr        (rf_wr),
		.even_data (even_data),
		.odd_data  (odd_data),
		.fsr_data  (fsr_data)
	);

	assign out_free  = !res_valid_q || !res_stall;
	assign s1_go     = valid_s1 && out_free;
	assign s1_done   = s1_go && (!dec.two_beat || beat_s1);
	assign cmd_stall = valid_s1 && !s1_done;
	assign cmd_take  = cmd_valid && !cmd_stall;

	// commit register writes only as the request leaves stage 1
	always_comb begin
		rf_wr           = '0;
		rf_wr.even_en   = s1_done && (dec.wr_pair || (dec.wr_single && !rd_s1[0]));
		rf_wr.odd_en    = s1_done && (dec.wr_pair || (dec.wr_single && rd_s1[0]));
		rf_wr.fsr_en    = s1_done && dec.wr_fsr;
		rf_wr.even_data = w0_s1;
		rf_wr.odd_data  = dec.wr_pair ? w1_s1 : w0_s1;
		rf_wr.fsr_data  = w0_s1;
	end

	assign pick_odd = dec.two_beat ? beat_s1 : rd_s1[0];

	always_comb begin
		if (!dec.mem_write) begin
			store_word = '0;
		end else if (dec.sel_fsr) begin
			store_word = (fsr_data & ~FSR_RESERVED_MASK) | FSR_VERSION_BITS;
		end else begin
			store_word = pick_odd ? odd_data : even_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			beat_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			// second beat of a double store follows the first
			if (s1_done) begin
				beat_s1 <= 1'b0;
			end else if (s1_go) begin
				beat_s1 <= 1'b1;
			end
			if (out_free) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			command_s1 <= command;
			imode_s1   <= immediate_mode;
			base_s1    <= base_value;
			index_s1   <= index_value;
			imm_s1     <= offset_immediate;
			rd_s1      <= fp_register_number;
			w0_s1      <= load_word_first;
			w1_s1      <= load_word_second;
			pc_s1      <= instruction_address;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			status_q    <= dec.status;
			mem_write_q <= dec.mem_write;
			mem_addr_q  <= beat_s1 ? dec.ea + WORD_STEP : dec.ea;
			mem_data_q  <= store_word;
			trap_addr_q <= dec.trap_addr;
			last_q      <= !dec.two_beat || beat_s1;
		end
	end

	assign res_valid      = res_valid_q;
	assign status         = status_q;
	assign memory_write   = mem_write_q;
	assign memory_address = mem_addr_q;
	assign memory_data    = mem_data_q;
	assign trap_address   = trap_addr_q;
	assign last           = last_q;

endmodule

### rtl/core/fls_checker.sv
// ----------------------------------------------------------------------------
// fls_checker
// Port-level checks of the FP load/store unit, bound to the top level.
// ----------------------------------------------------------------------------
module fls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [1:0]  status,
	input logic        memory_write,
	input logic [31:0] memory_address,
	input logic [31:0] trap_address,
	input logic        last
);
	import fls_pkg::*;

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// every accepted request shows a result once it has passed stage 1 and the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |-> ##2 res_valid)
		else $error("no result after accepted request");

	// second word of a double store follows at once, one word higher
	a_second_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !last |=>
			res_valid && last && memory_write && status == STAT_DONE &&
			memory_address == $past(memory_address) + WORD_STEP &&
			trap_address == $past(trap_address))
		else $error("double store second word wrong");

endmodule

bind fpu_load_store_unit fls_checker u_fls_checker (.*);
